>>> rtl/bts_pkg.sv
// Shared types and constants for the insertion-chain sorter (module bitonic_sorter).
`default_nettype none

package bts_pkg;

  // Default number of cells in the sorting chain
  localparam int SIZE_DEF = 64;
  localparam int VALUE_W  = 32;

  // Input word: one element of the set
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  // Output word: one element of the sorted set
  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_set;
  } result_t;

  // Contents of one cell
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } slot_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;      // place the incoming word in order
    logic shift_down;  // take the upper neighbor's contents
    logic shift_up;    // take the lower neighbor's contents
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/bts_cell.sv
// One cell of the sorting chain: holds a single element and trades with its neighbors.
`default_nettype none

module bts_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  bts_pkg::cell_ctl_t              ctl,
  input  logic signed [bts_pkg::VALUE_W-1:0] x,
  input  bts_pkg::slot_t                  lower,
  input  logic                            lower_ahead,
  input  bts_pkg::slot_t                  upper,
  output bts_pkg::slot_t                  slot,
  output logic                            ahead
);
  import bts_pkg::*;

  slot_t slot_next;

  // The incoming word goes ahead of this cell's element (empty cells rank last)
  assign ahead = !slot.valid || ($signed(x) < $signed(slot.value));

  // Choose the next contents: insert in order, or shift along the chain
  always_comb begin
    slot_next = slot;
    if (ctl.insert) begin
      if (lower_ahead) begin
        slot_next = lower;
      end else if (ahead) begin
        slot_next.valid = 1'b1;
        slot_next.value = x;
      end
    end else if (ctl.shift_down) begin
      slot_next = upper;
    end else if (ctl.shift_up) begin
      slot_next = lower;
    end
  end

  // Hold the element; reset empties the cell
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bitonic_sorter.sv
// Top level of the sorter: a chain of insertion cells with load and drain control.
//
//  channel  | direction | handshake                | word
//  ---------+-----------+--------------------------+---------------------------
//  item     | in        | item_valid / item_ready  | value, last
//  result   | out       | result_valid / result_ready | sorted_value, end_of_set
//  cfg      | in        | cfg_valid / cfg_ready    | cfg_data (ascending)
//
// Each word is placed in order across the cell chain in the cycle it is accepted;
// a word accepted while the chain is full is dropped. After the word marked last,
// the set drains at one word per cycle while result_ready is high, from cell 0
// (ascending) or, after shifting the set up to it, from the top cell (descending).
// Reset is synchronous and empties every cell; cfg is always ready.
// A stalled result holds in the end cell; no new word is taken until the set is out.
`default_nettype none

module bitonic_sorter #(
  parameter int SIZE = bts_pkg::SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  bts_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output bts_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);
  import bts_pkg::*;

  typedef enum logic {LOAD, DRAIN} phase_t;

  phase_t    phase;
  logic      ascending;
  cell_ctl_t ctl;
  slot_t     slots   [SIZE];
  logic      aheads  [SIZE];
  logic      item_take;
  logic      result_take;
  logic      full;

  assign cfg_ready   = 1'b1;
  assign item_ready  = (phase == LOAD);
  assign item_take   = item_valid && item_ready;
  assign result_take = result_valid && result_ready;
  assign full        = slots[SIZE-1].valid;

  // Present the end cell on the side the configured order drains from
  always_comb begin
    if (ascending) begin
      result_valid          = (phase == DRAIN) && slots[0].valid;
      result.sorted_value   = slots[0].value;
      result.end_of_set     = !slots[1].valid;
    end else begin
      result_valid          = (phase == DRAIN) && slots[SIZE-1].valid;
      result.sorted_value   = slots[SIZE-1].value;
      result.end_of_set     = !slots[SIZE-2].valid;
    end
  end

  // Drive the chain: insert on load (drop when full), shift on drain
  always_comb begin
    ctl.insert     = item_take && !full;
    ctl.shift_down = (phase == DRAIN) && ascending && result_take;
    ctl.shift_up   = (phase == DRAIN) && !ascending &&
                     (!slots[SIZE-1].valid || result_take);
  end

  // Advance the phase and hold the order register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= LOAD;
      ascending <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ascending <= cfg_data;
      end
      case (phase)
        LOAD: begin
          if (item_take && item.last) begin
            phase <= DRAIN;
          end
        end
        DRAIN: begin
          if (result_take && result.end_of_set) begin
            phase <= LOAD;
          end
        end
        default: phase <= LOAD;
      endcase
    end
  end

  // Build the chain of cells; the ends see empty neighbors
  for (genvar i = 0; i < SIZE; i++) begin : g_cell
    slot_t lower;
    slot_t upper;
    logic  lower_ahead;

    if (i == 0) begin : g_first
      assign lower       = '0;
      assign lower_ahead = 1'b0;
    end else begin : g_mid_lo
      assign lower       = slots[i-1];
      assign lower_ahead = aheads[i-1];
    end

    if (i == SIZE - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = slots[i+1];
    end

    bts_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .x           (item.value),
      .lower       (lower),
      .lower_ahead (lower_ahead),
      .upper       (upper),
      .slot        (slots[i]),
      .ahead       (aheads[i])
    );
  end

endmodule

`default_nettype wire

>>> rtl/bts_checker.sv
// Port-level checker for the sorter, bound to the top level.
`default_nettype none

module bts_checker (
  input wire             clk,
  input wire             rst,
  input wire             item_valid,
  input wire             item_ready,
  input bts_pkg::item_t   item,
  input wire             result_valid,
  input wire             result_ready,
  input bts_pkg::result_t result
);
  import bts_pkg::*;

  // Loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("input taken while a result is shown");

  // Closing word stops intake
  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.last) |=> !item_ready)
    else $error("intake open after the closing word");

  // Final result reopens intake
  a_end_reopens: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result.end_of_set) |=> item_ready)
    else $error("intake closed after the final result");

  // Stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind bitonic_sorter bts_checker u_bts_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
